// File: rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg - radix string converter shared definitions
// Digit alphabet, command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int BASE_W  = 7;
  localparam int CHAR_W  = 8;
  localparam int NUM_SYM = 83;

  // Leftmost character sits in the top byte.
  localparam logic [NUM_SYM*CHAR_W-1:0] ALPHA_STR =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz!?$#%&*+/-~[(<])>|';=";

  // Controller -> datapath commands
  typedef struct packed {
    logic load;        // capture a new request
    logic div_step;    // one restoring division step
    logic digit_wr;    // store remainder as next digit
    logic rd;          // fetch next digit, most significant first
    logic out_digit;   // present fetched digit as a character
    logic out_special; // present the bad-base or empty result
  } rsc_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic bad_base;
    logic q_zero;
    logic step_last;
    logic cnt_last;
    logic cnt_zero;
    logic out_free;
  } rsc_sts_t;

  // Digit to ASCII, digit taken modulo the alphabet size
  function automatic logic [CHAR_W-1:0] char_of(input logic [BASE_W-1:0] d);
    logic [BASE_W-1:0] j;
    j = (d >= BASE_W'(NUM_SYM)) ? d - BASE_W'(NUM_SYM) : d;
    return ALPHA_STR[(NUM_SYM - 1 - int'(j)) * CHAR_W +: CHAR_W];
  endfunction

endpackage

// File: rtl/rsc_ctrl.sv
// ----------------------------------------------------------------------------
// rsc_ctrl - radix string converter controller
// Sequences load, division, digit store and character emission.
// ----------------------------------------------------------------------------
module rsc_ctrl import rsc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rsc_sts_t sts,
  output rsc_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_SPECIAL, S_DIV, S_WR, S_RD, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.bad_base || sts.q_zero) state_nxt = S_SPECIAL;
        else                            state_nxt = S_DIV;
      end
      S_SPECIAL: begin
        if (sts.out_free) begin
          cmd.out_special = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) state_nxt = S_WR;
      end
      S_WR: begin
        cmd.digit_wr = 1'b1;
        // quotient already final here; stop on zero or a full store
        if (sts.q_zero || sts.cnt_last) state_nxt = S_RD;
        else                            state_nxt = S_DIV;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_digit = 1'b1;
          state_nxt     = sts.cnt_zero ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/rsc_dpath.sv
// ----------------------------------------------------------------------------
// rsc_dpath - radix string converter datapath
// Bit-serial divider, digit store, alphabet lookup and output register.
// ----------------------------------------------------------------------------
module rsc_dpath import rsc_pkg::*; #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_BASE    = 84,
  parameter int DIGIT_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [63:0]       in_value,
  input  logic [BASE_W-1:0] in_base,
  input  rsc_cmd_t          cmd,
  output rsc_sts_t          sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char_code,
  output logic              out_last,
  output logic              out_empty_res,
  output logic              out_bad_base
);

  localparam int IDX_W  = $clog2(DIGIT_DEPTH);
  localparam int CNT_W  = $clog2(DIGIT_DEPTH + 1);
  localparam int STEP_W = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] q_r;
  logic [BASE_W-1:0]      base_r;
  logic [BASE_W-1:0]      rem_r;
  logic [STEP_W-1:0]      step_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [BASE_W-1:0]      mem_q_r;
  logic                   out_valid_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_last_r;
  logic                   out_empty_r;
  logic                   out_bad_r;

  logic [BASE_W-1:0] digit_mem [DIGIT_DEPTH];

  logic [BASE_W:0]   trial;
  logic [BASE_W:0]   diff;
  logic              ge;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;

  // restoring step: shift next dividend bit into the partial remainder
  assign trial   = {rem_r, q_r[VALUE_WIDTH-1]};
  assign diff    = trial - {1'b0, base_r};
  assign ge      = (trial >= {1'b0, base_r});
  assign wr_addr = cnt_r[IDX_W-1:0];
  assign rd_addr = IDX_W'(cnt_r - 1'b1);

  assign sts.bad_base  = (base_r < BASE_W'(2)) || (base_r >= BASE_W'(MAX_BASE));
  assign sts.q_zero    = (q_r == '0);
  assign sts.step_last = (step_r == STEP_W'(VALUE_WIDTH - 1));
  assign sts.cnt_last  = (cnt_r == CNT_W'(DIGIT_DEPTH - 1));
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.digit_wr) begin
      digit_mem[wr_addr] <= rem_r;
    end
    if (cmd.rd) begin
      mem_q_r <= digit_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      step_r      <= '0;
    end else begin
      if (cmd.load) begin
        q_r    <= in_value[VALUE_WIDTH-1:0];
        base_r <= in_base;
        rem_r  <= '0;
        step_r <= '0;
        cnt_r  <= '0;
      end
      if (cmd.div_step) begin
        q_r    <= {q_r[VALUE_WIDTH-2:0], ge};
        rem_r  <= ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
        step_r <= step_r + 1'b1;
      end
      if (cmd.digit_wr) begin
        cnt_r  <= cnt_r + 1'b1;
        rem_r  <= '0;
        step_r <= '0;
      end
      if (cmd.rd) begin
        cnt_r <= cnt_r - 1'b1;
      end

      // a new result replaces one taken this cycle
      if (cmd.out_digit) begin
        out_valid_r <= 1'b1;
        out_char_r  <= char_of(mem_q_r);
        out_last_r  <= (cnt_r == '0);
        out_empty_r <= 1'b0;
        out_bad_r   <= 1'b0;
      end else if (cmd.out_special) begin
        out_valid_r <= 1'b1;
        out_char_r  <= '0;
        out_last_r  <= 1'b1;
        out_empty_r <= !sts.bad_base;
        out_bad_r   <= sts.bad_base;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_r;
  assign out_bad_base  = out_bad_r;

endmodule

// File: rtl/radix_string_converter_unit.sv
// ----------------------------------------------------------------------------
// radix_string_converter_unit - integer to base-N ASCII converter
// Divides the value by the base bit-serially, stores digits, emits characters.
// ----------------------------------------------------------------------------
// Results: a bad base or zero value gives a single result; otherwise every
//   digit is divided out and stored before the first character is emitted.
// Requests: one at a time, through the one-bit-per-cycle divider shared by all
//   digits and the registered digit store read; a new one is taken only when idle.
// Reset: rst_n synchronous active low; clears controller, counters, out_valid.
// ----------------------------------------------------------------------------
module radix_string_converter_unit import rsc_pkg::*; #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_BASE    = 84,
  parameter int DIGIT_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       in_value,
  input  logic [BASE_W-1:0] in_base,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char_code,
  output logic              out_last,
  output logic              out_empty_res,
  output logic              out_bad_base
);

  rsc_cmd_t cmd;
  rsc_sts_t sts;

  // Controller: one request at a time; input taken only when idle, while
  // the last result of the previous request may still sit in the out reg.
  rsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: value register doubles as quotient during restoring division;
  // digits land least significant first and are read back in reverse.
  rsc_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_BASE    (MAX_BASE),
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .in_base       (in_base),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .out_bad_base  (out_bad_base)
  );

endmodule

// File: rtl/rsc_checker.sv
// ----------------------------------------------------------------------------
// rsc_checker - port-level checks for the radix string converter
// Result handshake and result-kind consistency.
// ----------------------------------------------------------------------------
module rsc_checker import rsc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char_code,
  input logic              out_last,
  input logic              out_empty_res,
  input logic              out_bad_base
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code)
      && $stable(out_last) && $stable(out_empty_res) && $stable(out_bad_base))
    else $error("result dropped or changed while stalled");

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_base |-> out_last && !out_empty_res
      && (out_char_code == '0))
    else $error("bad-base result malformed");

  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last && (out_char_code == '0))
    else $error("empty result malformed");

  a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_res && !out_bad_base |-> (out_char_code != '0))
    else $error("digit result with null character");

endmodule

bind radix_string_converter_unit rsc_checker u_rsc_checker (.*);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench - radix string converter unit
// Drives conversion requests through a stimulus table, then random requests,
// with random stalls on both channels, and checks every character against a
// typed-in result or a local model of the repeated division and the digit alphabet.
// ----------------------------------------------------------------------------
module testbench import rsc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RADIX    = 84;    // first base that is rejected
  localparam int DIGIT_SLOTS  = 64;
  localparam int RANDOM_REQS  = 120;
  localparam int TAIL_REQS    = 20;    // last requests run with no idling
  localparam int HOLD_CYCLES  = 500;   // long receiver hold-off
  // Worst quiet stretch: dividing out all 64 digits, or the hold-off.
  localparam int STALL_LIMIT  = 20000;

  // One character on the result channel
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
    logic              empty_res;
    logic              bad_base;
  } char_result_t;

  // One row of the directed table; fixed_res is used when has_fixed is set
  typedef struct packed {
    logic [63:0]       value;
    logic [BASE_W-1:0] base;
    logic              has_fixed;
    char_result_t      fixed_res;
  } request_row_t;

  localparam logic [63:0] ALL_ONES = '1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [63:0]       in_value = '0;
  logic [BASE_W-1:0] in_base = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAR_W-1:0] out_char_code;
  logic              out_last;
  logic              out_empty_res;
  logic              out_bad_base;

  // Characters the block owes us, oldest first
  char_result_t pending_chars[$];

  // Local copy of the converter state
  logic [6:0]  conv_digits [DIGIT_SLOTS];
  logic [6:0]  conv_count;
  logic [63:0] conv_leftover;

  string symbol_set =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz!?$#%&*+/-~[(<])>|';=";

  int  mismatch_count = 0;
  int  chars_seen     = 0;
  int  sent_count     = 0;
  int  stall_cycles   = 0;
  bit  quiet_tail     = 1'b0;   // set for the closing stretch: no idling

  // Directed requests. Results are typed in where they are obvious: rejected
  // bases, zero values and single-digit numbers. The rest go to the model.
  request_row_t directed_rows [24] = '{
    '{64'd0,         7'd10,  1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},  // zero value
    '{64'd1,         7'd0,   1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},  // base 0
    '{64'd1,         7'd1,   1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},  // base 1
    '{64'd5,         7'd84,  1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},  // first bad base
    '{64'd0,         7'd127, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},  // bad beats zero
    '{ALL_ONES,      7'd0,   1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
    '{64'd0,         7'd2,   1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{64'd0,         7'd83,  1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{64'd1,         7'd2,   1'b1, '{8'h31, 1'b1, 1'b0, 1'b0}},  // "1"
    '{64'd35,        7'd36,  1'b1, '{8'h5A, 1'b1, 1'b0, 1'b0}},  // "Z"
    '{64'd61,        7'd62,  1'b1, '{8'h7A, 1'b1, 1'b0, 1'b0}},  // "z"
    '{64'd62,        7'd83,  1'b1, '{8'h21, 1'b1, 1'b0, 1'b0}},  // "!"
    '{64'd82,        7'd83,  1'b1, '{8'h3D, 1'b1, 1'b0, 1'b0}},  // "="
    '{64'd1,         7'd83,  1'b1, '{8'h31, 1'b1, 1'b0, 1'b0}},
    '{ALL_ONES,      7'd2,   1'b0, '0},                          // 64 digits
    '{ALL_ONES,      7'd83,  1'b0, '0},
    '{ALL_ONES,      7'd16,  1'b0, '0},
    '{64'h8000_0000_0000_0000, 7'd2, 1'b0, '0},
    '{64'd10,        7'd10,  1'b0, '0},
    '{64'd83,        7'd83,  1'b0, '0},
    '{ALL_ONES,      7'd10,  1'b0, '0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 7'd3,  1'b0, '0},
    '{64'h5555_5555_5555_5555, 7'd82, 1'b0, '0},
    '{64'd7,         7'd84,  1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}}
  };

  radix_string_converter_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_base      (in_base),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_last     (out_last),
    .out_empty_res(out_empty_res),
    .out_bad_base (out_bad_base)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Model of one conversion: queues the characters the request should give.
  // Rejected bases leave the state alone; the base check precedes the zero check.
  function automatic void predict_conversion(input logic [63:0] value,
                                             input logic [BASE_W-1:0] base);
    logic [63:0] quot;
    int          n;
    int          k;
    logic [6:0]  dig;
    quot = value;
    n    = 0;
    if (base < 7'd2 || int'(base) >= MAX_RADIX) begin
      pending_chars.push_back(char_result_t'{8'h00, 1'b1, 1'b0, 1'b1});
      return;
    end
    if (quot == 64'd0) begin
      conv_count    = '0;
      conv_leftover = '0;
      pending_chars.push_back(char_result_t'{8'h00, 1'b1, 1'b1, 1'b0});
      return;
    end
    // Least significant digit first; stops when the store is full
    while (quot != 64'd0 && n < DIGIT_SLOTS) begin
      conv_digits[n] = 7'(quot % 64'(base));
      quot           = quot / 64'(base);
      n++;
    end
    conv_count    = 7'(n);
    conv_leftover = quot;
    // Emit most significant first, last flag on the final character
    for (k = 0; k < n; k++) begin
      dig = conv_digits[n - 1 - k];
      pending_chars.push_back(char_result_t'{8'(symbol_set[int'(dig) % 83]),
                                             (k == n - 1), 1'b0, 1'b0});
    end
  endfunction

  task automatic log_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ns: %s", $time, what);
  endtask

  // Offer one request, hold it until taken, then book its expected characters
  task automatic send_request(input logic [63:0] value, input logic [BASE_W-1:0] base,
                              input logic has_fixed, input char_result_t fixed_res);
    in_value <= value;
    in_base  <= base;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (has_fixed) pending_chars.push_back(fixed_res);
    else predict_conversion(value, base);
    sent_count++;
  endtask

  // Random sender gap between requests; none in the closing stretch
  task automatic sender_gap();
    if (!quiet_tail && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Values of random bit length, so digit counts spread over the whole range
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          bits;
    v    = {$urandom, $urandom};
    bits = $urandom_range(1, 64);
    if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
    return v;
  endfunction

  // Main sequence: reset, directed table, random requests, drain, verdict
  initial begin : stimulus
    logic [63:0]       rval;
    logic [BASE_W-1:0] rbase;
    int                sel;
    int                i;
    conv_count    = '0;
    conv_leftover = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < $size(directed_rows); i++) begin
      send_request(directed_rows[i].value, directed_rows[i].base,
                   directed_rows[i].has_fixed, directed_rows[i].fixed_res);
      sender_gap();
    end

    // Mostly well-formed requests; some rejected bases and zero values
    for (i = 0; i < RANDOM_REQS; i++) begin
      if (i >= RANDOM_REQS - TAIL_REQS) quiet_tail = 1'b1;
      sel   = $urandom_range(0, 99);
      rval  = random_value();
      rbase = 7'($urandom_range(2, MAX_RADIX - 1));
      if (sel < 10) begin
        rbase = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 1))
                                            : 7'($urandom_range(MAX_RADIX, 127));
      end else if (sel < 18) begin
        rval = '0;
      end
      send_request(rval, rbase, 1'b0, '0);
      sender_gap();
    end
    in_valid <= 1'b0;

    // Drain, then allow a few cycles for anything stray to turn up
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: random ready bursts, plus one long hold-off once the random
  // part is under way, so the block backs up and refuses new requests.
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet_tail && !hold_done && sent_count >= 40) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Result checker and stall counter
  always @(posedge clk) begin
    char_result_t got;
    char_result_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (out_valid && out_ready) begin
        got = '{out_char_code, out_last, out_empty_res, out_bad_base};
        chars_seen++;
        if (pending_chars.size() == 0) begin
          log_mismatch($sformatf("unexpected char %0d: code %h last %b empty %b bad %b",
                                 chars_seen, got.char_code, got.last,
                                 got.empty_res, got.bad_base));
        end else begin
          want = pending_chars.pop_front();
          if (got != want) begin
            log_mismatch($sformatf(
              "char %0d: code %h/%h last %b/%b empty %b/%b bad %b/%b (exp/got)",
              chars_seen, want.char_code, got.char_code, want.last, got.last,
              want.empty_res, got.empty_res, want.bad_base, got.bad_base));
          end
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

endmodule
